[src/hrs_pkg.sv]
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types and constants for the HTTP response header scanner.
// ----------------------------------------------------------------------------
package hrs_pkg;

  // one received byte, or the end of the connection
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  // one header result
  typedef struct packed {
    logic [15:0] status_code;
    logic [30:0] body_length;
  } out_t;

  // where the scanner stands inside the current line
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_NUMBER = 2'd1,
    PH_REST   = 2'd2,
    PH_SKIPLF = 2'd3
  } phase_t;

  // what the parser hands to the output stage for one transfer
  typedef struct packed {
    logic        emit;
    logic [15:0] status;
    logic [30:0] length;
  } emit_t;

  localparam logic [7:0]  CH_CR      = 8'd13;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  CH_ZERO    = 8'd48;
  localparam logic [7:0]  CH_NINE    = 8'd57;
  localparam logic [30:0] NUM_MAX    = 31'h7FFF_FFFF;
  localparam logic [15:0] STATUS_MAX = 16'hFFFF;

  // keyword candidate bits
  localparam logic [1:0] CAND_STATUS = 2'b01;
  localparam logic [1:0] CAND_LENGTH = 2'b10;
  localparam logic [1:0] CAND_BOTH   = 2'b11;
  localparam logic [1:0] CAND_NONE   = 2'b00;

  localparam logic [3:0] KW_STATUS_LEN = 4'd8;
  localparam logic [3:0] KW_LENGTH_LEN = 4'd15;

  // "HTTP/1.1"
  localparam logic [7:0] KW_STATUS [8] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
  };

  // "Content-Length:"
  localparam logic [7:0] KW_LENGTH [15] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
  };

endpackage

[src/hrs_parser.sv]
// ----------------------------------------------------------------------------
// hrs_parser
// Line state, keyword match and number accumulation, one byte per transfer.
// ----------------------------------------------------------------------------
module hrs_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  hrs_pkg::in_t   item,
  output hrs_pkg::emit_t rsl
);

  hrs_pkg::phase_t phase, phase_next;
  logic [3:0]      pos, pos_next;
  logic [1:0]      mask, mask_next;
  logic            has_bytes, has_bytes_next;
  logic [30:0]     acc, acc_next;
  logic [15:0]     status, status_next;
  logic [30:0]     length, length_next;

  logic [1:0]  hit;
  logic        fin_commit;
  logic [1:0]  fin_mask;
  logic [30:0] fin_acc;
  logic        commit_en;
  logic [1:0]  commit_mask;
  logic [30:0] commit_acc;
  logic        fail_status, fail_length;
  logic [1:0]  mask_after;
  logic        is_digit;
  logic [34:0] acc_x10;
  logic [30:0] acc_sat;
  logic        emit;

  // keyword that the first word has fully matched
  always_comb begin
    if (mask[0] && pos == hrs_pkg::KW_STATUS_LEN) begin
      hit = hrs_pkg::CAND_STATUS;
    end else if (mask[1] && pos == hrs_pkg::KW_LENGTH_LEN) begin
      hit = hrs_pkg::CAND_LENGTH;
    end else begin
      hit = hrs_pkg::CAND_NONE;
    end
  end

  // finishing a line: commit the number or an empty keyword value
  assign fin_commit = (phase == hrs_pkg::PH_NUMBER) ||
                      (phase == hrs_pkg::PH_FIRST && hit != hrs_pkg::CAND_NONE);
  assign fin_mask   = (phase == hrs_pkg::PH_NUMBER) ? mask : hit;
  assign fin_acc    = (phase == hrs_pkg::PH_NUMBER) ? acc : '0;

  // keyword compare for a first-word byte
  assign fail_status = (pos >= hrs_pkg::KW_STATUS_LEN) ||
                       (hrs_pkg::KW_STATUS[pos[2:0]] != item.data_byte);
  assign fail_length = (pos >= hrs_pkg::KW_LENGTH_LEN) ||
                       (hrs_pkg::KW_LENGTH[(pos < hrs_pkg::KW_LENGTH_LEN) ? pos : 4'd0]
                        != item.data_byte);
  assign mask_after  = mask & {~fail_length, ~fail_status};

  // decimal accumulate with saturation
  assign is_digit = (item.data_byte >= hrs_pkg::CH_ZERO) &&
                    (item.data_byte <= hrs_pkg::CH_NINE);
  assign acc_x10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                    {31'd0, 4'(item.data_byte - hrs_pkg::CH_ZERO)};
  assign acc_sat  = (acc_x10 > {4'd0, hrs_pkg::NUM_MAX}) ? hrs_pkg::NUM_MAX
                                                        : acc_x10[30:0];

  // next state for one accepted byte
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    mask_next      = mask;
    has_bytes_next = has_bytes;
    acc_next       = acc;
    commit_en      = 1'b0;
    commit_mask    = mask;
    commit_acc     = acc;
    emit           = 1'b0;
    if (accept) begin
      if (item.stream_end) begin
        commit_en      = fin_commit;
        commit_mask    = fin_mask;
        commit_acc     = fin_acc;
        emit           = 1'b1;
        phase_next     = hrs_pkg::PH_FIRST;
        pos_next       = '0;
        mask_next      = hrs_pkg::CAND_BOTH;
        has_bytes_next = 1'b0;
        acc_next       = '0;
      end else if (phase == hrs_pkg::PH_SKIPLF) begin
        phase_next = hrs_pkg::PH_FIRST;
      end else if (item.data_byte == hrs_pkg::CH_CR) begin
        commit_en      = fin_commit;
        commit_mask    = fin_mask;
        commit_acc     = fin_acc;
        emit           = !has_bytes;
        phase_next     = hrs_pkg::PH_SKIPLF;
        pos_next       = '0;
        mask_next      = hrs_pkg::CAND_BOTH;
        has_bytes_next = 1'b0;
        acc_next       = '0;
      end else begin
        has_bytes_next = 1'b1;
        unique case (phase)
          hrs_pkg::PH_FIRST: begin
            if (item.data_byte == hrs_pkg::CH_SPACE) begin
              if (hit != hrs_pkg::CAND_NONE) begin
                mask_next  = hit;
                acc_next   = '0;
                phase_next = hrs_pkg::PH_NUMBER;
              end else begin
                phase_next = hrs_pkg::PH_REST;
              end
            end else begin
              mask_next = mask_after;
              if (mask_after == hrs_pkg::CAND_NONE) begin
                phase_next = hrs_pkg::PH_REST;
              end else begin
                pos_next = pos + 4'd1;
              end
            end
          end
          hrs_pkg::PH_NUMBER: begin
            if (is_digit) begin
              acc_next = acc_sat;
            end else begin
              commit_en  = 1'b1;
              phase_next = hrs_pkg::PH_REST;
            end
          end
          hrs_pkg::PH_REST, hrs_pkg::PH_SKIPLF: begin
            phase_next = hrs_pkg::PH_REST;
          end
        endcase
      end
    end
  end

  // commit into the stored values
  always_comb begin
    status_next = status;
    length_next = length;
    if (commit_en && commit_mask[0]) begin
      status_next = (commit_acc > {15'd0, hrs_pkg::STATUS_MAX}) ? hrs_pkg::STATUS_MAX
                                                               : commit_acc[15:0];
    end else if (commit_en && commit_mask[1]) begin
      length_next = commit_acc;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= hrs_pkg::PH_FIRST;
      pos       <= '0;
      mask      <= hrs_pkg::CAND_BOTH;
      has_bytes <= 1'b0;
      acc       <= '0;
      status    <= '0;
      length    <= '0;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      mask      <= mask_next;
      has_bytes <= has_bytes_next;
      acc       <= acc_next;
      status    <= status_next;
      length    <= length_next;
    end
  end

  assign rsl.emit   = emit;
  assign rsl.status = status_next;
  assign rsl.length = length_next;

`ifndef ASSERT_OFF
  // a number is only read for exactly one keyword
  a_number_one_keyword: assert property (@(posedge clk) disable iff (rst)
    phase == hrs_pkg::PH_NUMBER |-> $onehot(mask))
    else $error("number phase without a single keyword");

  // an untouched line starts from a clean match state
  a_empty_line_clean: assert property (@(posedge clk) disable iff (rst)
    !has_bytes |-> (pos == 4'd0 && mask == hrs_pkg::CAND_BOTH && acc == 31'd0))
    else $error("empty line with stale match state");

  // the number phase is only reached after bytes of the line
  a_number_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == hrs_pkg::PH_NUMBER |-> has_bytes)
    else $error("number phase on an empty line");
`endif

endmodule

[src/http_response_header_scanner_top.sv]
// ----------------------------------------------------------------------------
// http_response_header_scanner_top
// Scans HTTP response bytes and reports status code and content length.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel: one response byte per transfer (byte_data.data_byte), or a
//   transfer with byte_data.stream_end set when the connection closes.
//   result channel: one transfer per finished header (empty line or stream
//   end) carrying the stored status code and content length.
// Throughput: one byte per cycle while byte_stall is low; the scanner state is updated in the cycle
//   of the transfer by a single pass of logic ahead of the state registers.
// Result: result_valid is set in the cycle after the byte that ends the
//   header.
// Stall: results sit in a one-entry output register; byte_stall rises only
//   while that register is full and result_stall holds it, and clears in the
//   cycle the result is taken, so bytes keep flowing back to back.
// Reset: rst is synchronous; it clears the line state, both stored values
//   and result_valid; the result_data payload is not reset.
// ----------------------------------------------------------------------------
module http_response_header_scanner_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  hrs_pkg::in_t  byte_data,
  output logic          result_valid,
  input  logic          result_stall,
  output hrs_pkg::out_t result_data
);

  logic           accept;
  hrs_pkg::emit_t rsl;

  // input transfer
  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  hrs_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_data),
    .rsl    (rsl)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rsl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rsl.emit) begin
      result_data.status_code <= rsl.status;
      result_data.body_length <= rsl.length;
    end
  end

`ifndef ASSERT_OFF
  // bytes are held back only by a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid)
    else $error("byte stall without pending result");

  // a header end always shows a result next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    rsl.emit |=> result_valid)
    else $error("result lost");

  // a taken result without a new one leaves the register empty
  a_taken_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !rsl.emit) |=> !result_valid)
    else $error("result repeated");
`endif

endmodule
